// File: rtl/uartrx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrx_pkg
// Shared types and constants for the UART register block with receive buffer.
// ----------------------------------------------------------------------------
package uartrx_pkg;

	// Receive buffer geometry.
	localparam int BUFFER_DEPTH = 1024;
	localparam int PTR_W        = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = PTR_W + 1;

	// Field widths.
	localparam int CMD_W  = 2;
	localparam int OFS_W  = 10;
	localparam int DATA_W = 16;
	localparam int BYTE_W = 8;

	// Item kinds.
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RX    = 2'd2;

	// Register offsets.
	localparam logic [OFS_W-1:0] OFS_STATUS  = 10'h000;
	localparam logic [OFS_W-1:0] OFS_DATA    = 10'h004;
	localparam logic [OFS_W-1:0] OFS_CONTROL = 10'h00C;

	// Status and control bit positions.
	localparam int ST_RX_READY_BIT = 5;
	localparam int ST_TX_DONE_BIT  = 6;
	localparam int ST_TX_EMPTY_BIT = 7;
	localparam int CTL_RX_IE_BIT   = 5;
	localparam int CTL_TX_IE_BIT   = 7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;        // an item is taken this cycle
		logic pop_start;   // the item pops a stored byte: launch the buffer read
		logic pop_finish;  // buffer read data is valid: capture it as read data
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic buf_empty;
	} dp_status_t;

endpackage

// File: rtl/uart_rx_fifo_register_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_fifo_register_block
// UART register window with a linear receive buffer, one result per item.
// ----------------------------------------------------------------------------
//
// Channel  Handshake              Payload
// -------  ---------------------  -------------------------------------------
// in       in_valid / in_ready    cmd, reg_offset, write_data, rx_byte
// out      out_valid / out_ready  read_data, tx_valid, tx_byte, irq_pulse,
//                                 rx_dropped, free_space
//
// Most items have their result registered in the cycle after the transfer in, and a new item
// may be taken in the same cycle that the previous result is transferred out.
// A read of the data register with bytes stored passes through a pop state, set by the
// registered read port of the buffer RAM; no item is taken in that state.
// Reset is asynchronous and clears pointers, flags and the control word; the
// buffer contents are not cleared, since only written entries are ever read.
// A stall on the output holds the result and blocks new input transfers.
//
// Each item is a bus read, a bus write or one received line byte. Received
// bytes append to the buffer, reads of the data register pop them in order,
// and the space is reclaimed only when every stored byte has been popped.
// A byte that arrives with the buffer full is dropped and flagged.
module uart_rx_fifo_register_block (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [uartrx_pkg::CMD_W-1:0]    cmd,
	input  logic [uartrx_pkg::OFS_W-1:0]    reg_offset,
	input  logic [uartrx_pkg::DATA_W-1:0]   write_data,
	input  logic [uartrx_pkg::BYTE_W-1:0]   rx_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [uartrx_pkg::DATA_W-1:0]   read_data,
	output logic                            tx_valid,
	output logic [uartrx_pkg::BYTE_W-1:0]   tx_byte,
	output logic                            irq_pulse,
	output logic                            rx_dropped,
	output logic [uartrx_pkg::CNT_W-1:0]    free_space
);

	// Command and status between the controller and the datapath.
	uartrx_pkg::dp_cmd_t    dp_cmd;
	uartrx_pkg::dp_status_t dp_status;

	// The controller decides when an item is taken and when its result is
	// valid; it also sequences the buffer read of a data register pop.
	uartrx_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cmd        (cmd),
		.reg_offset (reg_offset),
		.dp_status  (dp_status),
		.dp_cmd     (dp_cmd)
	);

	// The datapath holds the register state, the buffer and the result fields.
	uartrx_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dp_cmd     (dp_cmd),
		.dp_status  (dp_status),
		.cmd        (cmd),
		.reg_offset (reg_offset),
		.write_data (write_data),
		.rx_byte    (rx_byte),
		.read_data  (read_data),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.irq_pulse  (irq_pulse),
		.rx_dropped (rx_dropped),
		.free_space (free_space)
	);

endmodule

// File: rtl/uartrx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uartrx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/uartrx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrx_ctrl
// Handshake controller: takes items, sequences buffer pops, owns output valid.
// ----------------------------------------------------------------------------
module uartrx_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	output logic                           out_valid,
	input  logic                           out_ready,
	input  logic [uartrx_pkg::CMD_W-1:0]   cmd,
	input  logic [uartrx_pkg::OFS_W-1:0]   reg_offset,
	input  uartrx_pkg::dp_status_t         dp_status,
	output uartrx_pkg::dp_cmd_t            dp_cmd
);

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   is_pop;

	assign is_pop = (cmd == uartrx_pkg::CMD_READ) && (reg_offset == uartrx_pkg::OFS_DATA);

	// A new item may enter once no pop is in flight and the result register is free or being emptied.
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);

	always_comb begin
		dp_cmd.exec       = in_valid && in_ready;
		dp_cmd.pop_start  = dp_cmd.exec && is_pop && !dp_status.buf_empty;
		dp_cmd.pop_finish = (state_q == S_POP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (dp_cmd.pop_start) begin
						state_q     <= S_POP;
						out_valid_q <= 1'b0;
					end else if (dp_cmd.exec) begin
						out_valid_q <= 1'b1;
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_POP: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// While a pop is in flight the result register must be empty.
	a_pop_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> !out_valid_q)
		else $error("pop in flight while a result is pending");

endmodule

// File: rtl/uartrx_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrx_dp
// Datapath: registers, receive buffer pointers, buffer RAM and result fields.
// ----------------------------------------------------------------------------
module uartrx_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  uartrx_pkg::dp_cmd_t             dp_cmd,
	output uartrx_pkg::dp_status_t          dp_status,
	input  logic [uartrx_pkg::CMD_W-1:0]    cmd,
	input  logic [uartrx_pkg::OFS_W-1:0]    reg_offset,
	input  logic [uartrx_pkg::DATA_W-1:0]   write_data,
	input  logic [uartrx_pkg::BYTE_W-1:0]   rx_byte,
	output logic [uartrx_pkg::DATA_W-1:0]   read_data,
	output logic                            tx_valid,
	output logic [uartrx_pkg::BYTE_W-1:0]   tx_byte,
	output logic                            irq_pulse,
	output logic                            rx_dropped,
	output logic [uartrx_pkg::CNT_W-1:0]    free_space
);

	localparam logic [uartrx_pkg::CNT_W-1:0] DEPTH_C =
		uartrx_pkg::CNT_W'(uartrx_pkg::BUFFER_DEPTH);

	// Architectural state.
	logic [uartrx_pkg::CNT_W-1:0]  fill_q;
	logic [uartrx_pkg::PTR_W-1:0]  pos_q;
	logic                          rdy_q;
	logic [uartrx_pkg::DATA_W-1:0] ctl_q;

	// Result registers.
	logic [uartrx_pkg::DATA_W-1:0] read_data_q;
	logic                          tx_valid_q;
	logic [uartrx_pkg::BYTE_W-1:0] tx_byte_q;
	logic                          irq_q;
	logic                          drop_q;
	logic [uartrx_pkg::CNT_W-1:0]  free_q;

	// Next-state and result logic.
	logic [uartrx_pkg::CNT_W-1:0]  fill_d;
	logic [uartrx_pkg::PTR_W-1:0]  pos_d;
	logic                          rdy_d;
	logic [uartrx_pkg::DATA_W-1:0] ctl_d;
	logic [uartrx_pkg::DATA_W-1:0] rd_d;
	logic                          txv_d;
	logic [uartrx_pkg::BYTE_W-1:0] txb_d;
	logic                          irq_d;
	logic                          drop_d;
	logic                          full;
	logic                          empty;
	logic [uartrx_pkg::CNT_W-1:0]  pos_inc;
	logic                          store_we;
	logic [uartrx_pkg::BYTE_W-1:0] ram_rdata;

	assign full    = (fill_q == DEPTH_C);
	assign empty   = (fill_q == '0);
	assign pos_inc = {1'b0, pos_q} + uartrx_pkg::CNT_W'(1);

	assign dp_status.buf_empty = empty;
	assign store_we = dp_cmd.exec && (cmd == uartrx_pkg::CMD_RX) && !full;

	always_comb begin
		fill_d = fill_q;
		pos_d  = pos_q;
		rdy_d  = rdy_q;
		ctl_d  = ctl_q;
		rd_d   = '0;
		txv_d  = 1'b0;
		txb_d  = '0;
		irq_d  = 1'b0;
		drop_d = 1'b0;
		unique case (cmd)
			uartrx_pkg::CMD_READ: begin
				if (reg_offset == uartrx_pkg::OFS_STATUS) begin
					rd_d[uartrx_pkg::ST_TX_DONE_BIT]  = 1'b1;
					rd_d[uartrx_pkg::ST_TX_EMPTY_BIT] = 1'b1;
					rd_d[uartrx_pkg::ST_RX_READY_BIT] = rdy_q;
				end else if (reg_offset == uartrx_pkg::OFS_DATA) begin
					// The byte itself is captured later from the registered read data of the RAM.
					if (empty) begin
						rdy_d = 1'b0;
					end else if (pos_inc >= fill_q) begin
						fill_d = '0;
						pos_d  = '0;
						rdy_d  = 1'b0;
					end else begin
						pos_d = pos_inc[uartrx_pkg::PTR_W-1:0];
					end
				end else if (reg_offset == uartrx_pkg::OFS_CONTROL) begin
					rd_d = ctl_q;
				end
			end
			uartrx_pkg::CMD_WRITE: begin
				if (reg_offset == uartrx_pkg::OFS_DATA) begin
					txv_d = 1'b1;
					txb_d = write_data[uartrx_pkg::BYTE_W-1:0];
					irq_d = ctl_q[uartrx_pkg::CTL_TX_IE_BIT];
				end else if (reg_offset == uartrx_pkg::OFS_CONTROL) begin
					ctl_d = write_data;
				end
			end
			uartrx_pkg::CMD_RX: begin
				if (!full) begin
					fill_d = fill_q + uartrx_pkg::CNT_W'(1);
					rdy_d  = 1'b1;
					irq_d  = ctl_q[uartrx_pkg::CTL_RX_IE_BIT];
				end else begin
					drop_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
			rdy_q  <= 1'b0;
			ctl_q  <= '0;
		end else if (dp_cmd.exec) begin
			fill_q <= fill_d;
			pos_q  <= pos_d;
			rdy_q  <= rdy_d;
			ctl_q  <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			read_data_q <= rd_d;
			tx_valid_q  <= txv_d;
			tx_byte_q   <= txb_d;
			irq_q       <= irq_d;
			drop_q      <= drop_d;
			free_q      <= DEPTH_C - fill_d;
		end else if (dp_cmd.pop_finish) begin
			read_data_q <= uartrx_pkg::DATA_W'(ram_rdata);
		end
	end

	uartrx_ram #(
		.WIDTH (uartrx_pkg::BYTE_W),
		.DEPTH (uartrx_pkg::BUFFER_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (fill_q[uartrx_pkg::PTR_W-1:0]),
		.wdata (rx_byte),
		.re    (dp_cmd.pop_start),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	assign read_data  = read_data_q;
	assign tx_valid   = tx_valid_q;
	assign tx_byte    = tx_byte_q;
	assign irq_pulse  = irq_q;
	assign rx_dropped = drop_q;
	assign free_space = free_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count beyond buffer depth");

	a_pos_below_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && pos_q == '0) || (!empty && {1'b0, pos_q} < fill_q))
		else $error("read position outside stored bytes");

	a_ready_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_q |-> !empty)
		else $error("receive-ready set with an empty buffer");

endmodule
